// ----- rtl/udsp_pkg.sv -----
// Package: shared types, constants and character helpers of the diagnostic response parser.
`default_nettype none

package udsp_pkg;

  localparam logic [7:0] NEG_RESPONSE_ID = 8'h7F;
  localparam logic [7:0] POS_OFFSET      = 8'h40;
  localparam logic [7:0] DTC_SERVICE     = 8'h19;
  localparam logic [7:0] SUB_NO_MASK_GAP = 8'h0A;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [7:0] ASCII_HEX_BASE  = 8'h37;
  localparam logic [7:0] ASCII_P         = 8'h50;
  localparam logic [7:0] ASCII_C         = 8'h43;
  localparam logic [7:0] ASCII_B         = 8'h42;
  localparam logic [7:0] ASCII_U         = 8'h55;
  localparam logic [1:0] LAST_HEADER_POS = 2'd3;
  localparam logic [1:0] LAST_REC_PHASE  = 2'd3;
  localparam int         QUEUE_DEPTH     = 3;
  localparam int         QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG     = 2'd1,
    ST_NOT_DTC = 2'd2
  } status_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    SYS_POWERTRAIN = 2'd0,
    SYS_CHASSIS    = 2'd1,
    SYS_BODY       = 2'd2,
    SYS_NETWORK    = 2'd3
  } system_e;

  typedef struct packed {
    kind_e       result_kind;
    status_e     status;
    logic [7:0]  service_id;
    logic [7:0]  subfunction;
    logic [7:0]  status_mask;
    logic [7:0]  reason_code;
    logic [7:0]  code_high;
    logic [7:0]  code_middle;
    logic [7:0]  code_low;
    logic [7:0]  code_state;
    logic [39:0] code_text;
    logic        is_last;
  } result_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] wide;
    wide = {4'b0000, v};
    return (v < 4'd10) ? (ASCII_ZERO + wide) : (ASCII_HEX_BASE + wide);
  endfunction

  function automatic logic [7:0] system_letter(input logic [1:0] sel);
    logic [7:0] ch;
    case (system_e'(sel))
      SYS_POWERTRAIN: ch = ASCII_P;
      SYS_CHASSIS:    ch = ASCII_C;
      SYS_BODY:       ch = ASCII_B;
      SYS_NETWORK:    ch = ASCII_U;
      default:        ch = ASCII_P;
    endcase
    return ch;
  endfunction

  function automatic logic [39:0] make_text(input logic [7:0] hi, input logic [7:0] mid);
    return {system_letter(hi[7:6]), ASCII_ZERO + {6'b000000, hi[5:4]},
            hex_char(hi[3:0]), hex_char(mid[7:4]), hex_char(mid[3:0])};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/udsp_parse.sv -----
// Packet state and per-byte decode into record and status results.
`default_nettype none

module udsp_parse
  import udsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output logic      [1:0]       res_count_o,
  output result_t               res0_o,
  output result_t               res1_o
);

  logic [1:0]  pos_q, pos_d;
  logic        neg_q, neg_d;
  logic [7:0]  svc_q, svc_d;
  logic [7:0]  sub_q, sub_d;
  logic [7:0]  mask_q, mask_d;
  logic [1:0]  phase_q, phase_d;
  logic [23:0] rec_q, rec_d;

  logic    dtc_ok;
  logic    feed;
  logic    emit;
  result_t rec_res;
  result_t stat_res;

  always_comb begin
    pos_d   = pos_q;
    neg_d   = neg_q;
    svc_d   = svc_q;
    sub_d   = sub_q;
    mask_d  = mask_q;
    phase_d = phase_q;
    rec_d   = rec_q;
    feed    = 1'b0;
    emit    = 1'b0;
    dtc_ok  = !neg_q && (svc_q == DTC_SERVICE);

    case (pos_q)
      2'd0: begin
        neg_d = (data_byte_i == NEG_RESPONSE_ID);
        svc_d = neg_d ? 8'h00 : (data_byte_i - POS_OFFSET);
      end
      2'd1: begin
        if (neg_q) begin
          svc_d = data_byte_i;
        end else begin
          sub_d = data_byte_i;
        end
      end
      2'd2: begin
        mask_d = data_byte_i;
        feed   = dtc_ok && (sub_q == SUB_NO_MASK_GAP);
      end
      default: begin
        feed = dtc_ok;
      end
    endcase

    if (feed) begin
      if (phase_q == LAST_REC_PHASE) begin
        emit    = 1'b1;
        phase_d = 2'd0;
        rec_d   = '0;
      end else begin
        phase_d = phase_q + 2'd1;
        rec_d   = {rec_q[15:0], data_byte_i};
      end
    end

    if (pos_q != LAST_HEADER_POS) begin
      pos_d = pos_q + 2'd1;
    end

    rec_res             = '0;
    rec_res.result_kind = KIND_RECORD;
    rec_res.status      = ST_OK;
    rec_res.service_id  = svc_q;
    rec_res.subfunction = sub_q;
    rec_res.status_mask = mask_q;
    rec_res.code_high   = rec_q[23:16];
    rec_res.code_middle = rec_q[15:8];
    rec_res.code_low    = rec_q[7:0];
    rec_res.code_state  = data_byte_i;
    rec_res.code_text   = make_text(rec_q[23:16], rec_q[15:8]);

    stat_res             = '0;
    stat_res.result_kind = KIND_STATUS;
    if (neg_d) begin
      stat_res.status = ST_NEG;
    end else if (svc_d != DTC_SERVICE) begin
      stat_res.status = ST_NOT_DTC;
    end else begin
      stat_res.status = ST_OK;
    end
    stat_res.service_id  = svc_d;
    stat_res.subfunction = neg_d ? 8'h00 : sub_d;
    stat_res.status_mask = neg_d ? 8'h00 : mask_d;
    stat_res.reason_code = neg_d ? mask_d : 8'h00;
    stat_res.is_last     = 1'b1;

    res_count_o = {1'b0, emit} + {1'b0, last_byte_i};
    res0_o      = emit ? rec_res : stat_res;
    res1_o      = stat_res;

    if (last_byte_i) begin
      pos_d   = '0;
      neg_d   = 1'b0;
      svc_d   = '0;
      sub_d   = '0;
      mask_d  = '0;
      phase_d = '0;
      rec_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      neg_q   <= 1'b0;
      svc_q   <= '0;
      sub_q   <= '0;
      mask_q  <= '0;
      phase_q <= '0;
      rec_q   <= '0;
    end else if (take_i) begin
      pos_q   <= pos_d;
      neg_q   <= neg_d;
      svc_q   <= svc_d;
      sub_q   <= sub_d;
      mask_q  <= mask_d;
      phase_q <= phase_d;
      rec_q   <= rec_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/udsp_outq.sv -----
// Result queue: three registered slots, up to two pushes and one pop per cycle.
`default_nettype none

module udsp_outq
  import udsp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [1:0]             push_count_i,
  input  wire result_t                push0_i,
  input  wire result_t                push1_i,
  input  wire logic                   pop_i,
  output logic      [QUEUE_CNT_W-1:0] count_o,
  output result_t                     head_o
);

  result_t                slot_q [QUEUE_DEPTH];
  result_t                slot_d [QUEUE_DEPTH];
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic [QUEUE_CNT_W-1:0] base;
  logic                   do_pop;

  always_comb begin
    do_pop = pop_i && (cnt_q != '0);
    base   = cnt_q - QUEUE_CNT_W'(do_pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if ((push_count_i != 2'd0) && (QUEUE_CNT_W'(i) == base)) begin
        slot_d[i] = push0_i;
      end
      if ((push_count_i == 2'd2) && (QUEUE_CNT_W'(i) == base + QUEUE_CNT_W'(1))) begin
        slot_d[i] = push1_i;
      end
    end
    cnt_d = base + QUEUE_CNT_W'(push_count_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign count_o = cnt_q;
  assign head_o  = slot_q[0];

endmodule

`default_nettype wire

// ----- rtl/uds_dtc_response_parser.sv -----
// Top level: diagnostic trouble code response parser.
// Usage:
//   Input channel carries one packet byte per transfer (data_byte_i, last_byte_i), with
//   in_valid_i from the sender and in_stall_o back to it. Output channel carries one
//   result per transfer, out_valid_o from this block and out_stall_i from the receiver.
//   Every complete four-byte trouble code record produces a record result; the last
//   byte of a packet produces a status result, after the record it completes, if any.
//   Results are registered in the result queue and presented from its head in order.
//   Throughput: one byte per cycle while in_stall_o is low. A byte that causes two
//   results fills two queue slots; the three-slot result queue then holds off the
//   next byte while it drains to one entry.
//   in_stall_o rises when two or more results wait; a receiver stall backs the queue
//   up and then holds off input until slots free up.
//   Reset clears the packet state and empties the queue; the first byte after reset
//   starts a new packet.
`default_nettype none

module uds_dtc_response_parser
  import udsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic      [1:0]  status_o,
  output logic      [7:0]  service_id_o,
  output logic      [7:0]  subfunction_o,
  output logic      [7:0]  status_mask_o,
  output logic      [7:0]  reason_code_o,
  output logic      [7:0]  code_high_o,
  output logic      [7:0]  code_middle_o,
  output logic      [7:0]  code_low_o,
  output logic      [7:0]  code_state_o,
  output logic      [39:0] code_text_o,
  output logic             is_last_o
);

  logic                   take;
  logic [1:0]             res_count;
  logic [1:0]             push_count;
  result_t                res0;
  result_t                res1;
  result_t                head;
  logic [QUEUE_CNT_W-1:0] q_count;

  assign in_stall_o = (q_count >= QUEUE_CNT_W'(2));
  assign take       = in_valid_i && !in_stall_o;
  assign push_count = take ? res_count : 2'd0;

  udsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_count_o (res_count),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  udsp_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .push0_i      (res0),
    .push1_i      (res1),
    .pop_i        (!out_stall_i),
    .count_o      (q_count),
    .head_o       (head)
  );

  assign out_valid_o   = (q_count != '0);
  assign result_kind_o = head.result_kind;
  assign status_o      = head.status;
  assign service_id_o  = head.service_id;
  assign subfunction_o = head.subfunction;
  assign status_mask_o = head.status_mask;
  assign reason_code_o = head.reason_code;
  assign code_high_o   = head.code_high;
  assign code_middle_o = head.code_middle;
  assign code_low_o    = head.code_low;
  assign code_state_o  = head.code_state;
  assign code_text_o   = head.code_text;
  assign is_last_o     = head.is_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input held off with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (take && last_byte_i) |=> out_valid_o)
    else $error("last byte transfer produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && (result_kind_o == KIND_RECORD)) |->
                   ((status_o == ST_OK) && !is_last_o))
    else $error("record result carries status or last flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- tb/uds_dtc_response_parser_tb.sv -----
// Testbench: packet-level stimulus and self-checking predictor for the trouble code response parser.
`default_nettype none

module uds_dtc_response_parser_tb;
  import udsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] POS_DTC_REPLY = DTC_SERVICE + POS_OFFSET;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam int         RANDOM_ITEMS  = 725;
  localparam int         PAUSE_AT      = 400;
  localparam int         LONG_HOLD_AT  = 300;
  localparam int         LONG_HOLD     = 80;
  localparam int         DRAIN_CYCLES  = 8;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       golden_en;
    result_t    golden;
  } byte_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        result_kind_o;
  logic [1:0]  status_o;
  logic [7:0]  service_id_o;
  logic [7:0]  subfunction_o;
  logic [7:0]  status_mask_o;
  logic [7:0]  reason_code_o;
  logic [7:0]  code_high_o;
  logic [7:0]  code_middle_o;
  logic [7:0]  code_low_o;
  logic [7:0]  code_state_o;
  logic [39:0] code_text_o;
  logic        is_last_o;

  logic        cur_golden_en = 1'b0;
  result_t     cur_golden    = '0;

  byte_item_t  packet_bytes[$];
  result_t     expected_results[$];
  int          err_count      = 0;
  int          accepted_count = 0;

  logic [1:0]  pkt_pos     = '0;
  logic        pkt_neg     = 1'b0;
  logic [7:0]  pkt_service = '0;
  logic [7:0]  pkt_subfn   = '0;
  logic [7:0]  pkt_mask    = '0;
  logic [1:0]  rec_phase   = '0;
  logic [23:0] rec_bytes   = '0;

  uds_dtc_response_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .service_id_o  (service_id_o),
    .subfunction_o (subfunction_o),
    .status_mask_o (status_mask_o),
    .reason_code_o (reason_code_o),
    .code_high_o   (code_high_o),
    .code_middle_o (code_middle_o),
    .code_low_o    (code_low_o),
    .code_state_o  (code_state_o),
    .code_text_o   (code_text_o),
    .is_last_o     (is_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    if (v < 4'd10) begin
      return ASCII_ZERO + 8'(v);
    end
    return ASCII_UPPER_A + 8'(v) - 8'd10;
  endfunction

  function automatic logic [39:0] dtc_text(input logic [7:0] hi, input logic [7:0] mid);
    logic [7:0] sys_char;
    case (system_e'(hi[7:6]))
      SYS_POWERTRAIN: sys_char = "P";
      SYS_CHASSIS:    sys_char = "C";
      SYS_BODY:       sys_char = "B";
      default:        sys_char = "U";
    endcase
    return {sys_char, ASCII_ZERO + 8'(hi[5:4]), nibble_ascii(hi[3:0]),
            nibble_ascii(mid[7:4]), nibble_ascii(mid[3:0])};
  endfunction

  function automatic result_t status_only(input status_e st, input logic [7:0] svc,
                                          input logic [7:0] reason);
    result_t r;
    r             = '0;
    r.result_kind = KIND_STATUS;
    r.status      = st;
    r.service_id  = svc;
    r.reason_code = reason;
    r.is_last     = 1'b1;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last, output result_t r0,
                             output result_t r1, output int n);
    logic    take;
    result_t st;
    take = 1'b0;
    n    = 0;
    r0   = '0;
    r1   = '0;
    if (pkt_pos == 2'd0) begin
      pkt_neg     = (b == NEG_RESPONSE_ID);
      pkt_service = pkt_neg ? 8'h00 : b - POS_OFFSET;
    end else if (pkt_pos == 2'd1) begin
      if (pkt_neg) begin
        pkt_service = b;
      end else begin
        pkt_subfn = b;
      end
    end else if (pkt_pos == 2'd2) begin
      pkt_mask = b;
      take     = !pkt_neg && pkt_service == DTC_SERVICE && pkt_subfn == SUB_NO_MASK_GAP;
    end else begin
      take = !pkt_neg && pkt_service == DTC_SERVICE;
    end
    if (take) begin
      if (rec_phase != LAST_REC_PHASE) begin
        rec_bytes = {rec_bytes[15:0], b};
        rec_phase = rec_phase + 2'd1;
      end else begin
        r0.result_kind = KIND_RECORD;
        r0.status      = ST_OK;
        r0.service_id  = pkt_service;
        r0.subfunction = pkt_subfn;
        r0.status_mask = pkt_mask;
        r0.code_high   = rec_bytes[23:16];
        r0.code_middle = rec_bytes[15:8];
        r0.code_low    = rec_bytes[7:0];
        r0.code_state  = b;
        r0.code_text   = dtc_text(rec_bytes[23:16], rec_bytes[15:8]);
        n              = 1;
        rec_phase      = '0;
        rec_bytes      = '0;
      end
    end
    if (pkt_pos != LAST_HEADER_POS) begin
      pkt_pos = pkt_pos + 2'd1;
    end
    if (last) begin
      if (pkt_neg) begin
        st = status_only(ST_NEG, pkt_service, pkt_mask);
      end else begin
        st = status_only((pkt_service == DTC_SERVICE) ? ST_OK : ST_NOT_DTC, pkt_service, 8'h00);
        st.subfunction = pkt_subfn;
        st.status_mask = pkt_mask;
      end
      if (n == 0) begin
        r0 = st;
      end else begin
        r1 = st;
      end
      n           = n + 1;
      pkt_pos     = '0;
      pkt_neg     = 1'b0;
      pkt_service = '0;
      pkt_subfn   = '0;
      pkt_mask    = '0;
      rec_phase   = '0;
      rec_bytes   = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic add_byte(input logic [7:0] data, input logic last);
    byte_item_t it;
    it.data      = data;
    it.last      = last;
    it.golden_en = 1'b0;
    it.golden    = '0;
    packet_bytes.push_back(it);
  endtask

  task automatic add_golden(input logic [7:0] data, input result_t golden);
    byte_item_t it;
    it.data      = data;
    it.last      = 1'b1;
    it.golden_en = 1'b1;
    it.golden    = golden;
    packet_bytes.push_back(it);
  endtask

  task automatic add_random_packet();
    int         mode;
    int         len;
    int         hdr;
    logic [7:0] sub;
    logic [7:0] b0;
    logic [7:0] b;
    mode = $urandom_range(0, 9);
    sub  = $urandom_range(0, 1) ? SUB_NO_MASK_GAP : 8'($urandom_range(0, 255));
    b0   = POS_DTC_REPLY;
    if (mode <= 5) begin
      hdr = (sub == SUB_NO_MASK_GAP) ? 2 : 3;
      len = hdr + 4 * $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) begin
        len = len + $urandom_range(1, 3);
      end
    end else if (mode == 6) begin
      b0  = NEG_RESPONSE_ID;
      len = $urandom_range(1, 8);
    end else if (mode == 7) begin
      b0  = 8'($urandom_range(0, 255));
      len = $urandom_range(1, 10);
    end else if (mode == 8) begin
      len = $urandom_range(1, 3);
    end else begin
      b0  = 8'($urandom_range(0, 255));
      sub = 8'($urandom_range(0, 255));
      len = $urandom_range(1, 12);
    end
    for (int j = 0; j < len; j++) begin
      if (j == 0) begin
        b = b0;
      end else if (j == 1) begin
        b = sub;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      add_byte(b, j == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t r0;
    result_t r1;
    int      n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {result_kind_o, status_o, service_id_o, subfunction_o, status_mask_o,
               reason_code_o, code_high_o, code_middle_o, code_low_o, code_state_o,
               code_text_o, is_last_o};
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 40'(want.result_kind), 40'(got.result_kind));
          check_field("status",      40'(want.status),      40'(got.status));
          check_field("service_id",  40'(want.service_id),  40'(got.service_id));
          check_field("subfunction", 40'(want.subfunction), 40'(got.subfunction));
          check_field("status_mask", 40'(want.status_mask), 40'(got.status_mask));
          check_field("reason_code", 40'(want.reason_code), 40'(got.reason_code));
          check_field("code_high",   40'(want.code_high),   40'(got.code_high));
          check_field("code_middle", 40'(want.code_middle), 40'(got.code_middle));
          check_field("code_low",    40'(want.code_low),    40'(got.code_low));
          check_field("code_state",  40'(want.code_state),  40'(got.code_state));
          check_field("code_text",   want.code_text,        got.code_text);
          check_field("is_last",     40'(want.is_last),     40'(got.is_last));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accepted_count++;
        decode_byte(data_byte_i, last_byte_i, r0, r1, n);
        if (cur_golden_en) begin
          expected_results.push_back(cur_golden);
        end else begin
          if (n > 0) begin
            expected_results.push_back(r0);
          end
          if (n > 1) begin
            expected_results.push_back(r1);
          end
        end
      end
    end
  end

  initial begin
    int seg_left;
    int stall_pct;
    bit long_done;
    seg_left  = 0;
    stall_pct = 0;
    long_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_done && accepted_count >= LONG_HOLD_AT) begin
        // hold off long enough for the result queue to fill and stall the input
        long_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 40);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    burst_left = 0;

    add_golden(POS_DTC_REPLY,   status_only(ST_OK, DTC_SERVICE, 8'h00));
    add_golden(NEG_RESPONSE_ID, status_only(ST_NEG, 8'h00, 8'h00));
    add_golden(8'h00,           status_only(ST_NOT_DTC, 8'hC0, 8'h00));
    add_golden(8'hFF,           status_only(ST_NOT_DTC, 8'hBF, 8'h00));
    // mask byte doubles as first record byte, record completes on the last byte
    add_byte(POS_DTC_REPLY, 1'b0);
    add_byte(SUB_NO_MASK_GAP, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'h4A, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'h01, 1'b1);
    add_byte(POS_DTC_REPLY, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(NEG_RESPONSE_ID, 1'b0);
    add_byte(DTC_SERVICE, 1'b0);
    add_byte(8'h31, 1'b0);
    add_byte(8'hAA, 1'b1);
    while (packet_bytes.size() < 25 + RANDOM_ITEMS) begin
      add_random_packet();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < packet_bytes.size(); i++) begin
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_results.size() != 0) @(posedge clk_i);
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left > 0) begin
        burst_left--;
      end
      in_valid_i    <= 1'b1;
      data_byte_i   <= packet_bytes[i].data;
      last_byte_i   <= packet_bytes[i].last;
      cur_golden_en <= packet_bytes[i].golden_en;
      cur_golden    <= packet_bytes[i].golden;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("uds_dtc_response_parser_tb: done, clean");
    end else begin
      $display("uds_dtc_response_parser_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("uds_dtc_response_parser_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
